// File: hw/rtl/assert_macros.svh
// Assertion helpers, clocked on aclk and held off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TGS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define TGS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/tgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tgs_pkg;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_DEC  = 2'd1,
        MODE_IBM  = 2'd2,
        MODE_UNI  = 2'd3
    } mode_t;

    localparam logic [7:0] BYTE_SO   = 8'h0E;
    localparam logic [7:0] BYTE_SI   = 8'h0F;
    localparam logic [7:0] BYTE_ESC  = 8'h1B;
    localparam logic [7:0] UTF_LEAD3 = 8'hE2;
    localparam logic [7:0] UTF_LEAD2 = 8'hC2;
    localparam logic [7:0] UTF_DOT   = 8'hB7;

    // Output queue depth is 2**QUEUE_AW; must be at least 4 entries.
    localparam int QUEUE_AW = 2;

    typedef struct packed {
        logic        shift_active;
        logic [1:0]  pend_count;
        logic [1:0][7:0] pend_bytes;
    } state_t;

    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } result_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
        logic       buffer_done;
    } entry_t;

    function automatic logic [7:0] dec_map(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h61:   r = "#";
            8'h60:   r = "*";
            8'h7E:   r = ".";
            8'h6E:   r = "+";
            8'h7B:   r = "_";
            8'd182:  r = "\\";
            8'd167:  r = "}";
            8'd187:  r = "{";
            8'd171:  r = "~";
            8'd168:  r = "~";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ibm_map(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'd177:  r = "#";
            8'd176:  r = "*";
            8'd249:  r = ".";
            8'd250:  r = ",";
            8'd254:  r = "+";
            8'd220:  r = "_";
            8'd239:  r = "\\";
            8'd244:  r = "}";
            8'd247:  r = "{";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // ASCII for E2 x y, zero when no sequence matches.
    function automatic logic [7:0] tri_match(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] r;
        r = 8'h00;
        if (x == 8'h96 && y == 8'h92) r = "#";
        if (x == 8'h96 && y == 8'h91) r = "*";
        if (x == 8'h97 && y == 8'hA6) r = ",";
        if (x == 8'h97 && y == 8'hBC) r = "+";
        if (x == 8'h88 && y == 8'hA9) r = "\\";
        if (x == 8'h8C && y == 8'hA0) r = "}";
        if (x == 8'h89 && y == 8'h88) r = "{";
        return r;
    endfunction

    function automatic logic tri_second(input logic [7:0] x);
        return x == 8'h96 || x == 8'h97 || x == 8'h88 || x == 8'h8C || x == 8'h89;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tgs_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// One byte through the stripper: up to three output bytes and the next state.
module tgs_filter (
    input  tgs_pkg::mode_t   mode,
    input  tgs_pkg::state_t  cur,
    input  logic [7:0]       data_byte,
    input  logic             eob,
    output tgs_pkg::result_t res,
    output tgs_pkg::state_t  nxt
);

    always_comb begin
        logic [1:0]      n;
        logic [2:0][7:0] bytes;
        logic            fresh;
        logic [7:0]      tri_out;
        logic [7:0]      step_out;
        logic [7:0]      mapped;

        n        = 2'd0;
        bytes    = '0;
        fresh    = 1'b0;
        tri_out  = 8'h00;
        step_out = data_byte;
        mapped   = 8'h00;
        nxt      = cur;

        if (mode == tgs_pkg::MODE_UNI) begin
            case (cur.pend_count)
                2'd0: begin
                    fresh = 1'b1;
                end
                2'd1: begin
                    if (cur.pend_bytes[0] == tgs_pkg::UTF_LEAD2 &&
                        data_byte == tgs_pkg::UTF_DOT) begin
                        nxt.pend_count = 2'd0;
                        bytes[0]       = ".";
                        n              = 2'd1;
                    end else if (cur.pend_bytes[0] == tgs_pkg::UTF_LEAD3 &&
                                 tgs_pkg::tri_second(data_byte)) begin
                        nxt.pend_bytes[1] = data_byte;
                        nxt.pend_count    = 2'd2;
                    end else begin
                        bytes[0]       = cur.pend_bytes[0];
                        n              = 2'd1;
                        nxt.pend_count = 2'd0;
                        fresh          = 1'b1;
                    end
                end
                default: begin
                    tri_out        = tgs_pkg::tri_match(cur.pend_bytes[1], data_byte);
                    nxt.pend_count = 2'd0;
                    if (tri_out != 8'h00) begin
                        bytes[0] = tri_out;
                        n        = 2'd1;
                    end else begin
                        bytes[0] = cur.pend_bytes[0];
                        bytes[1] = cur.pend_bytes[1];
                        n        = 2'd2;
                        fresh    = 1'b1;
                    end
                end
            endcase
            if (fresh) begin
                if (data_byte == tgs_pkg::UTF_LEAD3 || data_byte == tgs_pkg::UTF_LEAD2) begin
                    nxt.pend_bytes[0] = data_byte;
                    nxt.pend_count    = 2'd1;
                end else begin
                    bytes[n] = data_byte;
                    n        = n + 2'd1;
                end
            end
        end else begin
            // leftover partial match from a previous mode goes out first
            if (cur.pend_count != 2'd0) begin
                bytes[0] = cur.pend_bytes[0];
                n        = 2'd1;
            end
            if (cur.pend_count[1]) begin
                bytes[1] = cur.pend_bytes[1];
                n        = 2'd2;
            end
            nxt.pend_count = 2'd0;

            if (mode == tgs_pkg::MODE_IBM) begin
                mapped = tgs_pkg::ibm_map(data_byte);
                if (mapped != 8'h00) step_out = mapped;
            end else if (data_byte == tgs_pkg::BYTE_SO && !cur.shift_active) begin
                nxt.shift_active = 1'b1;
                step_out         = 8'h00;
            end else if ((data_byte == tgs_pkg::BYTE_SI || data_byte == tgs_pkg::BYTE_ESC) &&
                         cur.shift_active) begin
                nxt.shift_active = 1'b0;
            end else if (mode == tgs_pkg::MODE_DEC && cur.shift_active) begin
                mapped = tgs_pkg::dec_map(data_byte);
                if (mapped != 8'h00) step_out = mapped;
            end
            bytes[n] = step_out;
            n        = n + 2'd1;
        end

        if (eob) begin
            if (nxt.pend_count != 2'd0 && n != 2'd3) begin
                bytes[n] = nxt.pend_bytes[0];
                n        = n + 2'd1;
            end
            if (nxt.pend_count[1] && n != 2'd3) begin
                bytes[n] = nxt.pend_bytes[1];
                n        = n + 2'd1;
            end
            nxt.pend_count = 2'd0;
        end

        res.count = n;
        res.bytes = bytes;
    end

endmodule

`default_nettype wire

// File: hw/rtl/tgs_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Result queue: takes up to three entries a cycle, hands out one per transfer.
module tgs_out_queue #(
    parameter int QUEUE_AW = tgs_pkg::QUEUE_AW
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             push_count,
    input  tgs_pkg::entry_t [2:0]  push_data,
    output logic                   room,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tgs_pkg::entry_t        m_entry
);

    localparam int DEPTH = 1 << QUEUE_AW;
    localparam logic [QUEUE_AW+1:0] DEPTH_W = (QUEUE_AW + 2)'(DEPTH);

    tgs_pkg::entry_t       mem_reg [DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  pop;

    assign m_valid = count_reg != '0;
    assign pop     = m_valid && m_ready;
    assign m_entry = mem_reg[rd_ptr_reg];

    // room for a worst-case item of three results, counting this cycle's pop
    assign room = ({1'b0, count_reg} + (QUEUE_AW + 2)'(3)) <=
                  (DEPTH_W + (QUEUE_AW + 2)'(pop));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push_count);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + (QUEUE_AW + 1)'(push_count) - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < push_count) begin
                mem_reg[wr_ptr_reg + QUEUE_AW'(k)] <= push_data[k];
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/terminal_graphics_stripper.sv
// Terminal graphics stripper. Input bytes are taken one per transfer into an input
// register, filtered there combinationally and queued as result bytes in a small output
// queue (2**QUEUE_AW entries). Each byte is held in the input register until the queue
// has room for its results, which are offered on the output once written to the queue.
// Throughput is one input byte per cycle while each byte yields at most one result
// and m_ready stays high; an item yielding two or three results (flushed partial
// UTF-8 match) holds the input while the output port drains them, one byte per
// transfer. An item that only extends a partial match yields no result. s_ready
// depends combinationally on m_ready. A mode write (cfg_valid/cfg_mode, always ready)
// clears the shift state and any pending bytes; write it only when the block is idle.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module terminal_graphics_stripper #(
    parameter int QUEUE_AW = tgs_pkg::QUEUE_AW
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_mode,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_buffer,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_item,
    output logic       m_buffer_done
);

    tgs_pkg::mode_t   mode_reg;
    tgs_pkg::state_t  state_reg;
    tgs_pkg::state_t  state_next;
    tgs_pkg::result_t res;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eob_reg;

    logic                  room;
    logic                  advance;
    logic                  cfg_wr;
    logic [1:0]            push_count;
    tgs_pkg::entry_t [2:0] push_data;
    tgs_pkg::entry_t       m_entry;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign advance   = in_valid_reg && room;
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eob_reg  <= s_end_of_buffer;
        end
    end

    tgs_filter u_filter (
        .mode      (mode_reg),
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .eob       (in_eob_reg),
        .res       (res),
        .nxt       (state_next)
    );

    // mode, shift and count are control; pending bytes carry no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg               <= tgs_pkg::MODE_NONE;
            state_reg.shift_active <= 1'b0;
            state_reg.pend_count   <= 2'd0;
        end else if (cfg_wr) begin
            mode_reg               <= tgs_pkg::mode_t'(cfg_mode);
            state_reg.shift_active <= 1'b0;
            state_reg.pend_count   <= 2'd0;
        end else if (advance) begin
            state_reg.shift_active <= state_next.shift_active;
            state_reg.pend_count   <= state_next.pend_count;
            state_reg.pend_bytes   <= state_next.pend_bytes;
        end
    end

    always_comb begin
        push_count = advance ? res.count : 2'd0;
        for (int k = 0; k < 3; k++) begin
            push_data[k].out_byte     = res.bytes[k];
            push_data[k].last_of_item = (2'(k) == res.count - 2'd1);
            push_data[k].buffer_done  = (2'(k) == res.count - 2'd1) && in_eob_reg;
        end
    end

    tgs_out_queue #(
        .QUEUE_AW (QUEUE_AW)
    ) u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push_data  (push_data),
        .room       (room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_entry    (m_entry)
    );

    assign m_out_byte     = m_entry.out_byte;
    assign m_last_of_item = m_entry.last_of_item;
    assign m_buffer_done  = m_entry.buffer_done;

    `TGS_ASSERT_IMP(a_pend_bound, 1'b1, state_reg.pend_count != 2'd3)
    `TGS_ASSERT_IMP(a_pend_uni_only, mode_reg != tgs_pkg::MODE_UNI, state_reg.pend_count == 2'd0)
    `TGS_ASSERT_NXT(a_eob_flushes, advance && in_eob_reg, state_reg.pend_count == 2'd0)
    `TGS_ASSERT_IMP(a_eob_has_result, advance && in_eob_reg, res.count != 2'd0)

endmodule

`default_nettype wire

// File: sim/tb_terminal_graphics_stripper.sv
`timescale 1ns / 1ps

module tb_terminal_graphics_stripper;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    // glyph tables, keys and replacements kept in the same order
    localparam logic [9:0][7:0] DEC_KEY = {8'h61, 8'h60, 8'h7E, 8'h6E, 8'h7B,
                                           8'hB6, 8'hA7, 8'hBB, 8'hAB, 8'hA8};
    localparam logic [9:0][7:0] DEC_ASCII = {"#", "*", ".", "+", "_",
                                             8'h5C, "}", "{", "~", "~"};
    localparam logic [8:0][7:0] IBM_KEY = {8'hB1, 8'hB0, 8'hF9, 8'hFA, 8'hFE,
                                           8'hDC, 8'hEF, 8'hF4, 8'hF7};
    localparam logic [8:0][7:0] IBM_ASCII = {"#", "*", ".", ",", "+",
                                             "_", 8'h5C, "}", "{"};
    // second and third bytes of the E2 sequences
    localparam logic [6:0][15:0] TRI_SEQ = {16'h9692, 16'h9691, 16'h97A6, 16'h97BC,
                                            16'h88A9, 16'h8CA0, 16'h8988};
    localparam logic [6:0][7:0] TRI_ASCII = {"#", "*", ",", "+", 8'h5C, "}", "{"};

    typedef struct packed {
        logic [7:0] data;
        logic       eob;
    } raw_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_mode = 2'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_end_of_buffer = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_of_item;
    logic       m_buffer_done;

    raw_byte_t       raw_q[$];
    tgs_pkg::entry_t stripped_q[$];

    // predictor state
    tgs_pkg::mode_t cur_mode = tgs_pkg::MODE_NONE;
    logic           shifted = 1'b0;
    logic [7:0]     held [2];
    logic [1:0]     held_cnt = 2'd0;

    int bytes_unsent = 0;
    int bytes_in = 0;
    int bytes_out = 0;
    int mode_writes = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    int snd_idle_pct = 27;
    int rcv_idle_pct = 49;

    terminal_graphics_stripper u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_mode        (cfg_mode),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_buffer (s_end_of_buffer),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_of_item  (m_last_of_item),
        .m_buffer_done   (m_buffer_done)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] dec_glyph(input logic [7:0] b);
        for (int i = 0; i < 10; i++)
            if (DEC_KEY[i] == b) return DEC_ASCII[i];
        return 8'h00;
    endfunction

    function automatic logic [7:0] ibm_glyph(input logic [7:0] b);
        for (int i = 0; i < 9; i++)
            if (IBM_KEY[i] == b) return IBM_ASCII[i];
        return 8'h00;
    endfunction

    function automatic logic utf_second(input logic [7:0] b);
        for (int i = 0; i < 7; i++)
            if (TRI_SEQ[i][15:8] == b) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] utf_tri(input logic [7:0] x, input logic [7:0] y);
        for (int i = 0; i < 7; i++)
            if (TRI_SEQ[i] == {x, y}) return TRI_ASCII[i];
        return 8'h00;
    endfunction

    // works out the result bytes of one input byte and queues them
    task automatic strip_byte(input logic [7:0] b, input logic eob);
        logic [7:0]      outs[$];
        logic [7:0]      hit;
        logic            fresh;
        tgs_pkg::entry_t e;
        fresh = 1'b0;
        if (cur_mode == tgs_pkg::MODE_UNI) begin
            if (held_cnt == 2'd0) begin
                fresh = 1'b1;
            end else if (held_cnt == 2'd1) begin
                if (held[0] == tgs_pkg::UTF_LEAD2 && b == tgs_pkg::UTF_DOT) begin
                    outs.push_back(".");
                    held_cnt = 2'd0;
                end else if (held[0] == tgs_pkg::UTF_LEAD3 && utf_second(b)) begin
                    held[1] = b;
                    held_cnt = 2'd2;
                end else begin
                    outs.push_back(held[0]);
                    held_cnt = 2'd0;
                    fresh = 1'b1;
                end
            end else begin
                hit = utf_tri(held[1], b);
                held_cnt = 2'd0;
                if (hit != 8'h00) begin
                    outs.push_back(hit);
                end else begin
                    outs.push_back(held[0]);
                    outs.push_back(held[1]);
                    fresh = 1'b1;
                end
            end
            if (fresh) begin
                if (b == tgs_pkg::UTF_LEAD3 || b == tgs_pkg::UTF_LEAD2) begin
                    held[0] = b;
                    held_cnt = 2'd1;
                end else begin
                    outs.push_back(b);
                end
            end
        end else begin
            for (int i = 0; i < held_cnt; i++) outs.push_back(held[i]);
            held_cnt = 2'd0;
            if (cur_mode == tgs_pkg::MODE_IBM) begin
                hit = ibm_glyph(b);
                outs.push_back(hit != 8'h00 ? hit : b);
            end else if (b == tgs_pkg::BYTE_SO && !shifted) begin
                shifted = 1'b1;
                outs.push_back(8'h00);
            end else if ((b == tgs_pkg::BYTE_SI || b == tgs_pkg::BYTE_ESC) && shifted) begin
                shifted = 1'b0;
                outs.push_back(b);
            end else if (cur_mode == tgs_pkg::MODE_DEC && shifted && dec_glyph(b) != 8'h00) begin
                outs.push_back(dec_glyph(b));
            end else begin
                outs.push_back(b);
            end
        end
        if (eob) begin
            for (int i = 0; i < held_cnt && outs.size() < 3; i++) outs.push_back(held[i]);
            held_cnt = 2'd0;
        end
        foreach (outs[k]) begin
            e.out_byte = outs[k];
            e.last_of_item = (k == outs.size() - 1);
            e.buffer_done = e.last_of_item && eob;
            stripped_q.push_back(e);
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch #%0d: %s", $realtime, mismatches, what);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eob);
        raw_byte_t r;
        r.data = b;
        r.eob = eob;
        raw_q.push_back(r);
        bytes_unsent++;
    endtask

    task automatic set_mode(input tgs_pkg::mode_t m);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_mode <= m;
        do @(posedge aclk); while (!cfg_ready);
        cur_mode = m;
        shifted = 1'b0;
        held_cnt = 2'd0;
        mode_writes++;
        cfg_valid <= 1'b0;
    endtask

    // wait for every byte to be taken and every result to come back
    task automatic drain();
        while (bytes_unsent != 0 || stripped_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic fill_random(input int count);
        int start;
        int k;
        logic [7:0] lead;
        start = bytes_unsent;
        while (bytes_unsent - start < count) begin
            if (cur_mode == tgs_pkg::MODE_UNI) begin
                k = $urandom_range(6);
                lead = $urandom_range(1) ? tgs_pkg::UTF_LEAD3 : tgs_pkg::UTF_LEAD2;
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        push_byte(tgs_pkg::UTF_LEAD3, $urandom_range(7) == 0);
                        push_byte(TRI_SEQ[k][15:8], $urandom_range(7) == 0);
                        push_byte(TRI_SEQ[k][7:0], $urandom_range(7) == 0);
                    end
                    4: begin
                        push_byte(tgs_pkg::UTF_LEAD2, $urandom_range(7) == 0);
                        push_byte(tgs_pkg::UTF_DOT, $urandom_range(7) == 0);
                    end
                    5: begin
                        push_byte(tgs_pkg::UTF_LEAD3, 1'b0);
                        push_byte(TRI_SEQ[k][15:8], 1'b0);
                        push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
                    end
                    6: begin
                        push_byte(lead, 1'b0);
                        push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
                    end
                    7: push_byte(8'h00, $urandom_range(7) == 0);
                    8: push_byte(lead, 1'b1);
                    default: push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
                endcase
            end else if (cur_mode == tgs_pkg::MODE_IBM) begin
                case ($urandom_range(7))
                    0, 1, 2, 3: push_byte(IBM_KEY[$urandom_range(8)], $urandom_range(7) == 0);
                    4: push_byte(tgs_pkg::BYTE_SO, $urandom_range(7) == 0);
                    default: push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
                endcase
            end else begin
                case ($urandom_range(7))
                    0: push_byte(tgs_pkg::BYTE_SO, $urandom_range(7) == 0);
                    1: push_byte(tgs_pkg::BYTE_SI, $urandom_range(7) == 0);
                    2: push_byte(tgs_pkg::BYTE_ESC, $urandom_range(7) == 0);
                    3, 4, 5: push_byte(DEC_KEY[$urandom_range(9)], $urandom_range(7) == 0);
                    default: push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
                endcase
            end
        end
    endtask

    // input driver: prediction is made at the edge the transfer happens
    always @(posedge aclk) begin
        raw_byte_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                strip_byte(s_data_byte, s_end_of_buffer);
                bytes_unsent--;
                bytes_in++;
            end
            if (!s_valid || s_ready) begin
                if (raw_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    r = raw_q.pop_front();
                    s_valid <= 1'b1;
                    s_data_byte <= r.data;
                    s_end_of_buffer <= r.eob;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        tgs_pkg::entry_t want;
        if (aresetn && m_valid && m_ready) begin
            bytes_out++;
            if (stripped_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result byte %02h", m_out_byte));
            end else begin
                want = stripped_q.pop_front();
                if (m_out_byte !== want.out_byte)
                    note_mismatch($sformatf("out_byte %02h, want %02h",
                                            m_out_byte, want.out_byte));
                if (m_last_of_item !== want.last_of_item)
                    note_mismatch($sformatf("last_of_item %b, want %b (byte %02h)",
                                            m_last_of_item, want.last_of_item, want.out_byte));
                if (m_buffer_done !== want.buffer_done)
                    note_mismatch($sformatf("buffer_done %b, want %b (byte %02h)",
                                            m_buffer_done, want.buffer_done, want.out_byte));
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: shift handling with no mapping
        set_mode(tgs_pkg::MODE_NONE);
        push_byte(tgs_pkg::BYTE_SO, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(tgs_pkg::BYTE_SO, 1'b0);
        push_byte(tgs_pkg::BYTE_SI, 1'b0);
        push_byte(tgs_pkg::BYTE_ESC, 1'b0);
        push_byte(8'hFF, 1'b1);
        drain();

        set_mode(tgs_pkg::MODE_DEC);
        push_byte(tgs_pkg::BYTE_SO, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'hB6, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(tgs_pkg::BYTE_ESC, 1'b0);
        push_byte(8'h61, 1'b1);
        drain();

        set_mode(tgs_pkg::MODE_IBM);
        push_byte(8'hB1, 1'b0);
        push_byte(8'hDC, 1'b0);
        push_byte(tgs_pkg::BYTE_SO, 1'b0);
        push_byte(8'h80, 1'b1);
        drain();

        // two- and three-byte matches, NUL in the stream, partial match flushed at end
        set_mode(tgs_pkg::MODE_UNI);
        push_byte(tgs_pkg::UTF_LEAD2, 1'b0);
        push_byte(tgs_pkg::UTF_DOT, 1'b0);
        push_byte(tgs_pkg::UTF_LEAD3, 1'b0);
        push_byte(8'h96, 1'b0);
        push_byte(8'h92, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(tgs_pkg::UTF_LEAD3, 1'b0);
        push_byte(8'h97, 1'b1);
        drain();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin snd_idle_pct = 27; rcv_idle_pct = 49; end
                1: begin snd_idle_pct = 49; rcv_idle_pct = 27; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            for (int k = 0; k < 4; k++) begin
                set_mode(tgs_pkg::mode_t'(2'((k + p) % 4)));
                fill_random(15);
                drain();
            end
        end

        $display("run covered %0d input bytes and %0d result bytes over %0d mode writes,",
                 bytes_in, bytes_out, mode_writes);
        $display("all four modes under three idling profiles; %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/tgs_pkg.sv
hw/rtl/tgs_filter.sv
hw/rtl/tgs_out_queue.sv
hw/rtl/terminal_graphics_stripper.sv
sim/tb_terminal_graphics_stripper.sv
